### rtl/core/fmb_pkg.sv
// Shared types, codes and saturating arithmetic for the spin Fock matrix build.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package fmb_pkg;

  localparam int VAL_W     = 64;
  localparam int IDX_W     = 3;
  localparam int CMD_W     = 3;
  localparam int BASIS_W   = 4;
  localparam int FRAC_BITS = 40;

  typedef logic signed [VAL_W-1:0] fx_t;

  localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_H   = 3'd0,
    CMD_LOAD_PA  = 3'd1,
    CMD_LOAD_PB  = 3'd2,
    CMD_LOAD_ERI = 3'd3,
    CMD_BUILD    = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_PT,
    S_MJ,
    S_MJW,
    S_MXA,
    S_MXAW,
    S_MXB,
    S_MXBW,
    S_HRD,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic h;
    logic pa;
    logic pb;
    logic ten;
  } wr_en_t;

  typedef struct packed {
    logic mat;
    logic ten;
    logic h;
  } rd_en_t;

  function automatic fx_t sat_add(fx_t a, fx_t b);
    fx_t s;
    s = a + b;
    if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1]) begin
      return a[VAL_W-1] ? FX_MIN : FX_MAX;
    end
    return s;
  endfunction

  function automatic fx_t sat_sub(fx_t a, fx_t b);
    fx_t d;
    d = a - b;
    if (a[VAL_W-1] != b[VAL_W-1] && d[VAL_W-1] != a[VAL_W-1]) begin
      return a[VAL_W-1] ? FX_MIN : FX_MAX;
    end
    return d;
  endfunction

endpackage

### rtl/core/fmb_mul.sv
// Q24.40 multiplier: sign-magnitude product from four 32x32 partial products,
// one per cycle, then round half away from zero and saturate. Uses fmb_pkg.
`timescale 1ns / 1ps

module fmb_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  fmb_pkg::fx_t a,
  input  fmb_pkg::fx_t b,
  output logic         done,
  output fmb_pkg::fx_t result
);
  import fmb_pkg::*;

  logic         busy_r;
  logic [2:0]   step_r;
  logic         done_r;
  logic         neg_r;
  logic [63:0]  ma_r, mb_r;
  logic [127:0] acc_r;
  fx_t          result_r;

  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [6:0]   shamt;
  logic [127:0] pp_sh;
  logic [127:0] rnd;
  logic [63:0]  mag;
  fx_t          fin;

  always_comb begin
    unique case (step_r[1:0])
      2'd0: begin opa = ma_r[31:0];  opb = mb_r[31:0];  shamt = 7'd0;  end
      2'd1: begin opa = ma_r[31:0];  opb = mb_r[63:32]; shamt = 7'd32; end
      2'd2: begin opa = ma_r[63:32]; opb = mb_r[31:0];  shamt = 7'd32; end
      default: begin opa = ma_r[63:32]; opb = mb_r[63:32]; shamt = 7'd64; end
    endcase
    pp    = opa * opb;
    pp_sh = {64'b0, pp} << shamt;
  end

  // Rounding is applied to the magnitude, so halves go away from zero.
  always_comb begin
    rnd = acc_r + (128'd1 << (FRAC_BITS - 1));
    mag = rnd[FRAC_BITS+63:FRAC_BITS];
    if (|rnd[127:FRAC_BITS+64]) begin
      fin = neg_r ? FX_MIN : FX_MAX;
    end else if (neg_r) begin
      fin = mag[63] ? FX_MIN : -$signed(mag);
    end else begin
      fin = mag[63] ? FX_MAX : $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= a[63] ^ b[63];
      ma_r  <= a[63] ? 64'(-a) : 64'(a);
      mb_r  <= b[63] ? 64'(-b) : 64'(b);
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r == 3'd4) begin
        result_r <= fin;
      end else begin
        acc_r <= acc_r + pp_sh;
      end
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

### rtl/core/fmb_store.sv
// Element stores: core Hamiltonian, alpha and beta densities and the integral
// tensor, each a synchronous memory with registered read data. Uses fmb_pkg.
`timescale 1ns / 1ps

module fmb_store #(
  parameter int IW = 3
) (
  input  logic                  clk,
  input  fmb_pkg::wr_en_t       wr,
  input  logic [2*IW-1:0]       mat_waddr,
  input  logic [4*IW-1:0]       ten_waddr,
  input  fmb_pkg::fx_t          wdata,
  input  fmb_pkg::rd_en_t       rd,
  input  logic [2*IW-1:0]       mat_raddr,
  input  logic [2*IW-1:0]       h_raddr,
  input  logic [4*IW-1:0]       coul_raddr,
  input  logic [4*IW-1:0]       exch_raddr,
  output fmb_pkg::fx_t          pa_q,
  output fmb_pkg::fx_t          pb_q,
  output fmb_pkg::fx_t          h_q,
  output fmb_pkg::fx_t          coul_q,
  output fmb_pkg::fx_t          exch_q
);
  import fmb_pkg::*;

  localparam int MAT_D = 1 << (2 * IW);
  localparam int TEN_D = 1 << (4 * IW);

  fx_t h_mem   [MAT_D];
  fx_t pa_mem  [MAT_D];
  fx_t pb_mem  [MAT_D];
  fx_t ten_mem [TEN_D];

  always_ff @(posedge clk) begin
    if (wr.h) begin
      h_mem[mat_waddr] <= wdata;
    end
    if (rd.h) begin
      h_q <= h_mem[h_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.pa) begin
      pa_mem[mat_waddr] <= wdata;
    end
    if (rd.mat) begin
      pa_q <= pa_mem[mat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.pb) begin
      pb_mem[mat_waddr] <= wdata;
    end
    if (rd.mat) begin
      pb_q <= pb_mem[mat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.ten) begin
      ten_mem[ten_waddr] <= wdata;
    end
    if (rd.ten) begin
      coul_q <= ten_mem[coul_raddr];
      exch_q <= ten_mem[exch_raddr];
    end
  end

endmodule

### rtl/core/spin_fock_matrix_build.sv
// Spin-separated Fock matrix build. Load items (core H, alpha density, beta
// density, integral) are written to memory as they are taken. A build item
// walks every (row, col) pair of the active basis in row-major order; for each
// pair it steps through all n*n (r, s) terms, each made of one memory read, the
// total density add and three Q24.40 products on one shared multiplier; each
// product is a start step, then the four 32x32 partial products, a rounding
// step and a step that hands over the result. Each pair then reads core H and
// loads the output register, which waits while the output is stalled. No new
// item is taken until the build's last result has entered the output register.
// Uses fmb_pkg, fmb_store and fmb_mul.
`timescale 1ns / 1ps

module spin_fock_matrix_build #(
  parameter int MAX_BASIS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fmb_pkg::CMD_W-1:0]     in_command,
  input  logic [fmb_pkg::IDX_W-1:0]     in_index_p,
  input  logic [fmb_pkg::IDX_W-1:0]     in_index_q,
  input  logic [fmb_pkg::IDX_W-1:0]     in_index_r,
  input  logic [fmb_pkg::IDX_W-1:0]     in_index_s,
  input  logic signed [fmb_pkg::VAL_W-1:0] in_load_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fmb_pkg::IDX_W-1:0]     out_row_index,
  output logic [fmb_pkg::IDX_W-1:0]     out_col_index,
  output logic signed [fmb_pkg::VAL_W-1:0] out_fock_alpha,
  output logic signed [fmb_pkg::VAL_W-1:0] out_fock_beta,
  output logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [fmb_pkg::BASIS_W-1:0]   cfg_wr_data
);
  import fmb_pkg::*;

  localparam int IW = $clog2(MAX_BASIS);

  function automatic logic [BASIS_W-1:0] clamp_basis(logic [BASIS_W-1:0] v);
    if (v == '0) begin
      return BASIS_W'(1);
    end else if (int'(v) > MAX_BASIS) begin
      return BASIS_W'(MAX_BASIS);
    end
    return v;
  endfunction

  seq_state_t state_r, state_nxt;
  logic [BASIS_W-1:0] basis_r;
  logic [IW-1:0] i_r, j_r, k_r, l_r;
  logic [IW-1:0] i_nxt, j_nxt, k_nxt, l_nxt;
  fx_t ga_r, gb_r, pt_r;
  fx_t ga_nxt, gb_nxt, pt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   out_row_r, out_col_r;
  fx_t                out_fa_r, out_fb_r;
  logic               out_last_r;
  logic               out_load;

  wr_en_t wr;
  rd_en_t rd;
  fx_t pa_q, pb_q, h_q, coul_q, exch_q;
  logic mul_start, mul_done;
  fx_t mul_a, mul_b, mul_res;

  logic [BASIS_W-1:0] n_m1;
  logic k_last, l_last, i_last, j_last, term_last, pair_last;
  logic in_fire, pq_ok, rs_ok;
  cmd_t cmd;

  assign n_m1      = basis_r - BASIS_W'(1);
  assign k_last    = BASIS_W'(k_r) == n_m1;
  assign l_last    = BASIS_W'(l_r) == n_m1;
  assign i_last    = BASIS_W'(i_r) == n_m1;
  assign j_last    = BASIS_W'(j_r) == n_m1;
  assign term_last = k_last && l_last;
  assign pair_last = i_last && j_last;

  assign in_fire = in_valid && in_ready;
  assign cmd     = cmd_t'(in_command);
  assign pq_ok   = (int'(in_index_p) < MAX_BASIS) && (int'(in_index_q) < MAX_BASIS);
  assign rs_ok   = (int'(in_index_r) < MAX_BASIS) && (int'(in_index_s) < MAX_BASIS);
  assign out_load = !out_valid_r || out_ready;

  fmb_store #(.IW(IW)) u_store (
    .clk        (clk),
    .wr         (wr),
    .mat_waddr  ({IW'(in_index_p), IW'(in_index_q)}),
    .ten_waddr  ({IW'(in_index_p), IW'(in_index_q), IW'(in_index_r), IW'(in_index_s)}),
    .wdata      (in_load_value),
    .rd         (rd),
    .mat_raddr  ({k_r, l_r}),
    .h_raddr    ({i_r, j_r}),
    .coul_raddr ({i_r, j_r, k_r, l_r}),
    .exch_raddr ({i_r, k_r, j_r, l_r}),
    .pa_q       (pa_q),
    .pb_q       (pb_q),
    .h_q        (h_q),
    .coul_q     (coul_q),
    .exch_q     (exch_q)
  );

  fmb_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && cmd == CMD_BUILD) begin
          state_nxt = S_RD;
        end
      end
      S_RD:  state_nxt = S_PT;
      S_PT:  state_nxt = S_MJ;
      S_MJ:  state_nxt = S_MJW;
      S_MJW: begin
        if (mul_done) begin
          state_nxt = S_MXA;
        end
      end
      S_MXA: state_nxt = S_MXAW;
      S_MXAW: begin
        if (mul_done) begin
          state_nxt = S_MXB;
        end
      end
      S_MXB: state_nxt = S_MXBW;
      S_MXBW: begin
        if (mul_done) begin
          state_nxt = term_last ? S_HRD : S_RD;
        end
      end
      S_HRD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          state_nxt = pair_last ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = 1'b0;
    wr        = '0;
    rd        = '0;
    mul_start = 1'b0;
    mul_a     = pt_r;
    mul_b     = coul_q;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          case (cmd)
            CMD_LOAD_H:   wr.h   = pq_ok;
            CMD_LOAD_PA:  wr.pa  = pq_ok;
            CMD_LOAD_PB:  wr.pb  = pq_ok;
            CMD_LOAD_ERI: wr.ten = pq_ok && rs_ok;
            default: ;
          endcase
        end
      end
      S_RD: begin
        rd.mat = 1'b1;
        rd.ten = 1'b1;
      end
      S_MJ: mul_start = 1'b1;
      S_MXA: begin
        mul_start = 1'b1;
        mul_a     = pa_q;
        mul_b     = exch_q;
      end
      S_MXB: begin
        mul_start = 1'b1;
        mul_a     = pb_q;
        mul_b     = exch_q;
      end
      S_HRD: rd.h = 1'b1;
      default: ;
    endcase
  end

  // Counters and accumulators.
  always_comb begin
    i_nxt  = i_r;
    j_nxt  = j_r;
    k_nxt  = k_r;
    l_nxt  = l_r;
    ga_nxt = ga_r;
    gb_nxt = gb_r;
    pt_nxt = pt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && cmd == CMD_BUILD) begin
          i_nxt  = '0;
          j_nxt  = '0;
          k_nxt  = '0;
          l_nxt  = '0;
          ga_nxt = '0;
          gb_nxt = '0;
        end
      end
      S_PT: pt_nxt = sat_add(pa_q, pb_q);
      S_MJW: begin
        if (mul_done) begin
          ga_nxt = sat_add(ga_r, mul_res);
          gb_nxt = sat_add(gb_r, mul_res);
        end
      end
      S_MXAW: begin
        if (mul_done) begin
          ga_nxt = sat_sub(ga_r, mul_res);
        end
      end
      S_MXBW: begin
        if (mul_done) begin
          gb_nxt = sat_sub(gb_r, mul_res);
          if (l_last) begin
            l_nxt = '0;
            k_nxt = k_last ? '0 : k_r + IW'(1);
          end else begin
            l_nxt = l_r + IW'(1);
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          ga_nxt = '0;
          gb_nxt = '0;
          if (j_last) begin
            j_nxt = '0;
            i_nxt = i_last ? '0 : i_r + IW'(1);
          end else begin
            j_nxt = j_r + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      basis_r     <= clamp_basis(BASIS_W'(8));
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        basis_r <= clamp_basis(cfg_wr_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    k_r  <= k_nxt;
    l_r  <= l_nxt;
    ga_r <= ga_nxt;
    gb_r <= gb_nxt;
    pt_r <= pt_nxt;
    if (state_r == S_EMIT && out_load) begin
      out_row_r  <= IDX_W'(i_r);
      out_col_r  <= IDX_W'(j_r);
      out_fa_r   <= sat_add(h_q, ga_r);
      out_fb_r   <= sat_add(h_q, gb_r);
      out_last_r <= pair_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_index  = out_row_r;
  assign out_col_index  = out_col_r;
  assign out_fock_alpha = out_fa_r;
  assign out_fock_beta  = out_fb_r;
  assign out_last       = out_last_r;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for spin_fock_matrix_build: directed table, store fill,
// then random load/build phases checked against an in-bench Q24.40 Fock predictor.
// Depends on fmb_pkg and the spin_fock_matrix_build RTL.
`timescale 1ns / 1ps

module testbench;
  import fmb_pkg::*;

  localparam int  NB          = 8;
  localparam int  FILL_N      = 3;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  SETTLE      = 40;
  localparam logic [2:0] CMD_SPARE0 = 3'd5;
  localparam logic [2:0] CMD_SPARE1 = 3'd6;
  localparam logic [2:0] CMD_SPARE2 = 3'd7;
  localparam fx_t ONE  = 64'sh0000_0100_0000_0000;
  localparam fx_t HALF = 64'sh0000_0080_0000_0000;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] p, q, r, s;
    fx_t        val;
    logic       typed;
    fx_t        fa, fb;
  } stim_row_t;

  typedef struct packed {
    logic [2:0] row, col;
    fx_t        fa, fb;
    logic       last;
  } fock_elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [2:0] in_command = '0, in_index_p = '0, in_index_q = '0;
  logic [2:0] in_index_r = '0, in_index_s = '0;
  logic signed [63:0] in_load_value = '0;
  logic out_valid, out_ready = 1'b0;
  logic [2:0] out_row_index, out_col_index;
  logic signed [63:0] out_fock_alpha, out_fock_beta;
  logic out_last;
  logic cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = '0;

  fx_t ham [NB*NB];
  fx_t dens_a [NB*NB];
  fx_t dens_b [NB*NB];
  fx_t eri [NB*NB*NB*NB];
  int  basis_n;
  fock_elem_t fock_expected[$];
  stim_row_t  table_rows[$];
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;

  spin_fock_matrix_build #(.MAX_BASIS(NB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_index_p(in_index_p), .in_index_q(in_index_q), .in_index_r(in_index_r),
    .in_index_s(in_index_s), .in_load_value(in_load_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_row_index(out_row_index),
    .out_col_index(out_col_index), .out_fock_alpha(out_fock_alpha),
    .out_fock_beta(out_fock_beta), .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic fx_t q_add(fx_t a, fx_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return s[63:0];
  endfunction

  function automatic fx_t q_sub(fx_t a, fx_t b);
    logic signed [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) return d[64] ? FX_MIN : FX_MAX;
    return d[63:0];
  endfunction

  // Exact product, rounded half away from zero on the magnitude, then saturated.
  function automatic fx_t q_mul(fx_t a, fx_t b);
    logic [127:0] pr, mag;
    logic neg;
    pr  = {{64{a[63]}}, a} * {{64{b[63]}}, b};
    neg = a[63] ^ b[63];
    mag = neg ? -pr : pr;
    mag = (mag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (neg) return (mag >= (128'd1 << 63)) ? FX_MIN : -fx_t'(mag[63:0]);
    return (mag > 128'h7FFF_FFFF_FFFF_FFFF) ? FX_MAX : fx_t'(mag[63:0]);
  endfunction

  function automatic int clamp_basis(logic [3:0] v);
    if (v == 0) return 1;
    if (v > NB) return NB;
    return int'(v);
  endfunction

  task automatic predict_fock_build();
    fx_t ga, gb, pt, jt;
    fock_elem_t e;
    for (int i = 0; i < basis_n; i++) begin
      for (int j = 0; j < basis_n; j++) begin
        ga = '0;
        gb = '0;
        for (int k = 0; k < basis_n; k++) begin
          for (int l = 0; l < basis_n; l++) begin
            pt = q_add(dens_a[k*NB+l], dens_b[k*NB+l]);
            jt = q_mul(pt, eri[((i*NB+j)*NB+k)*NB+l]);
            ga = q_add(ga, jt);
            gb = q_add(gb, jt);
            ga = q_sub(ga, q_mul(dens_a[k*NB+l], eri[((i*NB+k)*NB+j)*NB+l]));
            gb = q_sub(gb, q_mul(dens_b[k*NB+l], eri[((i*NB+k)*NB+j)*NB+l]));
          end
        end
        e.row  = 3'(i);
        e.col  = 3'(j);
        e.fa   = q_add(ham[i*NB+j], ga);
        e.fb   = q_add(ham[i*NB+j], gb);
        e.last = (i == basis_n - 1 && j == basis_n - 1);
        fock_expected.push_back(e);
      end
    end
  endtask

  task automatic apply_item(stim_row_t it);
    fock_elem_t e;
    case (it.cmd)
      CMD_LOAD_H:   ham[it.p*NB+it.q] = it.val;
      CMD_LOAD_PA:  dens_a[it.p*NB+it.q] = it.val;
      CMD_LOAD_PB:  dens_b[it.p*NB+it.q] = it.val;
      CMD_LOAD_ERI: eri[((it.p*NB+it.q)*NB+it.r)*NB+it.s] = it.val;
      CMD_BUILD: begin
        if (it.typed) begin
          e = '{row: 3'd0, col: 3'd0, fa: it.fa, fb: it.fb, last: 1'b1};
          fock_expected.push_back(e);
        end else begin
          predict_fock_build();
        end
      end
      default: ;
    endcase
  endtask

  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < 38);
  endfunction

  task automatic send_item(stim_row_t it);
    @(negedge clk);
    while (idle_roll()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_command    = it.cmd;
    in_index_p    = it.p;
    in_index_q    = it.q;
    in_index_r    = it.r;
    in_index_s    = it.s;
    in_load_value = it.val;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_item(it);
  endtask

  // Holds the sender until every expected element has come, then lets the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (fock_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_basis(logic [3:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    basis_n   = clamp_basis(v);
  endtask

  function automatic stim_row_t mk(logic [2:0] cmd, int p, int q, int r, int s, fx_t val,
                                   logic typed = 1'b0, fx_t fa = '0, fx_t fb = '0);
    return '{cmd: cmd, p: 3'(p), q: 3'(q), r: 3'(r), s: 3'(s), val: val,
             typed: typed, fa: fa, fb: fb};
  endfunction

  function automatic fx_t small_value();
    return fx_t'({{22{1'b0}}, $urandom(), 10'($urandom())}) - (fx_t'(1) << 41);
  endfunction

  function automatic fx_t rand_value();
    case ($urandom_range(0, 5))
      0: return {$urandom(), $urandom()};
      1: return FX_MAX;
      2: return FX_MIN;
      3: return '0;
      default: return small_value();
    endcase
  endfunction

  function automatic stim_row_t rand_load();
    return mk(3'($urandom_range(CMD_LOAD_H, CMD_LOAD_ERI)), $urandom_range(0, 7),
              $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
              rand_value());
  endfunction

  task automatic report(string what, fx_t got, fx_t want);
    $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  always @(negedge clk) begin
    out_ready <= rst_n && !idle_roll();
  end

  always @(posedge clk) begin
    fock_elem_t e;
    if (rst_n && out_valid && out_ready) begin
      if (fock_expected.size() == 0) begin
        report("unexpected item", out_fock_alpha, '0);
      end else begin
        e = fock_expected.pop_front();
        if (out_row_index !== e.row)
          report("row_index", fx_t'(out_row_index), fx_t'(e.row));
        if (out_col_index !== e.col)
          report("col_index", fx_t'(out_col_index), fx_t'(e.col));
        if (out_fock_alpha !== e.fa) report("fock_alpha", out_fock_alpha, e.fa);
        if (out_fock_beta !== e.fb) report("fock_beta", out_fock_beta, e.fb);
        if (out_last !== e.last) report("last", fx_t'(out_last), fx_t'(e.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int n_items;
    basis_n = clamp_basis(4'd8);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at one basis function; writing zero clamps to one.
    write_basis(4'd0);
    table_rows.push_back(mk(CMD_LOAD_H, 0, 0, 0, 0, 64'sd5 <<< FRAC_BITS));
    table_rows.push_back(mk(CMD_LOAD_PA, 0, 0, 0, 0, '0));
    table_rows.push_back(mk(CMD_LOAD_PB, 0, 0, 0, 0, '0));
    table_rows.push_back(mk(CMD_LOAD_ERI, 0, 0, 0, 0, '0));
    table_rows.push_back(mk(CMD_BUILD, 0, 0, 0, 0, '0, 1'b1,
                            64'sd5 <<< FRAC_BITS, 64'sd5 <<< FRAC_BITS));
    // Core H at the top of the range saturates once the two-electron part is added.
    table_rows.push_back(mk(CMD_LOAD_H, 0, 0, 0, 0, FX_MAX));
    table_rows.push_back(mk(CMD_LOAD_PA, 0, 0, 0, 0, ONE));
    table_rows.push_back(mk(CMD_LOAD_PB, 0, 0, 0, 0, ONE));
    table_rows.push_back(mk(CMD_LOAD_ERI, 0, 0, 0, 0, ONE));
    table_rows.push_back(mk(CMD_BUILD, 7, 7, 7, 7, FX_MAX, 1'b1, FX_MAX, FX_MAX));
    table_rows.push_back(mk(CMD_LOAD_H, 0, 0, 0, 0, FX_MIN));
    table_rows.push_back(mk(CMD_LOAD_PA, 0, 0, 0, 0, -ONE));
    table_rows.push_back(mk(CMD_LOAD_PB, 0, 0, 0, 0, -ONE));
    table_rows.push_back(mk(CMD_BUILD, 0, 0, 0, 0, '0, 1'b1, FX_MIN, FX_MIN));
    // Unused commands must be dropped without a result.
    table_rows.push_back(mk(CMD_SPARE0, 7, 7, 7, 7, FX_MAX));
    table_rows.push_back(mk(CMD_SPARE1, 0, 0, 0, 0, FX_MIN));
    table_rows.push_back(mk(CMD_SPARE2, 7, 0, 7, 0, -64'sd1));
    table_rows.push_back(mk(CMD_LOAD_H, 7, 7, 0, 0, -64'sd1));
    table_rows.push_back(mk(CMD_LOAD_ERI, 7, 7, 7, 7, FX_MAX));
    table_rows.push_back(mk(CMD_LOAD_PA, 0, 0, 0, 0, HALF));
    table_rows.push_back(mk(CMD_LOAD_PB, 0, 0, 0, 0, 64'sd3));
    table_rows.push_back(mk(CMD_LOAD_ERI, 0, 0, 0, 0, ONE + HALF + 64'sd1));
    table_rows.push_back(mk(CMD_BUILD, 0, 0, 0, 0, '0));
    foreach (table_rows[i]) send_item(table_rows[i]);
    drain();

    // Fill every entry that a build of up to FILL_N basis functions reads.
    write_basis(4'(FILL_N));
    for (int a = 0; a < FILL_N * FILL_N; a++) begin
      send_item(mk(CMD_LOAD_H, a / FILL_N, a % FILL_N, 0, 0, small_value()));
      send_item(mk(CMD_LOAD_PA, a / FILL_N, a % FILL_N, 0, 0, small_value()));
      send_item(mk(CMD_LOAD_PB, a / FILL_N, a % FILL_N, 0, 0, small_value()));
    end
    for (int a = 0; a < FILL_N ** 4; a++) begin
      send_item(mk(CMD_LOAD_ERI, a / (FILL_N ** 3), (a / (FILL_N * FILL_N)) % FILL_N,
                   (a / FILL_N) % FILL_N, a % FILL_N, small_value()));
    end
    send_item(mk(CMD_BUILD, 0, 0, 0, 0, '0));
    drain();

    // Random phases; the last one runs at the largest filled basis size.
    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 4 || ph == 5);
      write_basis(ph == 0 ? 4'd1 : ph == 9 ? 4'(FILL_N) : 4'($urandom_range(0, FILL_N)));
      n_items = $urandom_range(6, 10);
      for (int k = 0; k < n_items; k++) begin
        if (k == n_items - 1) begin
          send_item(mk(CMD_BUILD, $urandom_range(0, 7), $urandom_range(0, 7),
                       $urandom_range(0, 7), $urandom_range(0, 7), rand_value()));
        end else if (ph != 9 && $urandom_range(0, 9) == 0) begin
          send_item(mk(CMD_BUILD, 0, 0, 0, 0, '0));
        end else if ($urandom_range(0, 19) == 0) begin
          send_item(mk(3'($urandom_range(CMD_SPARE0, CMD_SPARE2)), $urandom_range(0, 7),
                       $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                       rand_value()));
        end else begin
          send_item(rand_load());
        end
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/fmb_pkg.sv
rtl/core/fmb_mul.sv
rtl/core/fmb_store.sv
rtl/core/spin_fock_matrix_build.sv
tb/sv/testbench.sv
